// File: src/i2cb_pkg.sv
// Shared types and constants for the I2C register-burst master.
// Used by i2cb_front, i2cb_engine and i2c_master_register_burst.
package i2cb_pkg;

  localparam int unsigned DATA_W = 56;

  // Raw command codes on the input stream.
  localparam logic [1:0] CMD_CODE_TICK  = 2'd0;
  localparam logic [1:0] CMD_CODE_WRITE = 2'd1;
  localparam logic [1:0] CMD_CODE_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] CFG_PHASE      = 2'd1;
  localparam logic [1:0] CFG_GAP        = 2'd2;

  localparam logic [6:0]  SLAVE_ADDR_RST = 7'd104;
  localparam logic [11:0] PHASE_RST      = 12'd250;
  localparam logic [15:0] GAP_RST        = 16'd16;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_WRITE,
    KIND_READ
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         reg_addr;
    logic [DATA_W-1:0]  write_data;
    logic               sda_in;
  } item_t;

  typedef struct packed {
    logic               scl_release;
    logic               sda_release;
    logic               busy_res;
    logic               read_done;
    logic [DATA_W-1:0]  read_data;
    logic               cmd_rejected;
  } res_t;

endpackage

// File: src/i2cb_front.sv
// Input side of the I2C burst master: classifies each tick item and
// queues it in a two-entry FIFO. Depends on i2cb_pkg.
module i2cb_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_cmd,
  input  logic [7:0]           in_reg_addr,
  input  logic [i2cb_pkg::DATA_W-1:0] in_write_data,
  input  logic                 in_sda,
  output logic                 q_valid,
  output i2cb_pkg::item_t      q_item,
  input  logic                 q_pop
);

  i2cb_pkg::item_t slots [2];
  logic [1:0]      count;
  logic            wr_ptr;
  logic            rd_ptr;
  logic            push;
  i2cb_pkg::item_t item_in;

  always_comb begin
    unique case (in_cmd)
      i2cb_pkg::CMD_CODE_WRITE: item_in.kind = i2cb_pkg::KIND_WRITE;
      i2cb_pkg::CMD_CODE_READ:  item_in.kind = i2cb_pkg::KIND_READ;
      default:                  item_in.kind = i2cb_pkg::KIND_TICK;
    endcase
    item_in.reg_addr   = in_reg_addr;
    item_in.write_data = in_write_data;
    item_in.sda_in     = in_sda;
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) q_pop |-> count != 2'd0)
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
      (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers out of step with count");
`endif

endmodule

// File: src/i2cb_engine.sv
// Bus sequencer of the I2C burst master: runs one tick per queued item,
// drives the line levels and holds the result register. Depends on i2cb_pkg.
module i2cb_engine #(
  parameter int unsigned BURST_BYTES = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 q_valid,
  input  i2cb_pkg::item_t      q_item,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output i2cb_pkg::res_t       res
);

  localparam logic [2:0] LAST_BYTE = 3'(BURST_BYTES - 1);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'd0,
    ST_START     = 5'd1,
    ST_AW_LO     = 5'd2,
    ST_AW_HI     = 5'd3,
    ST_RG_LO     = 5'd4,
    ST_RG_HI     = 5'd5,
    ST_AR_LO     = 5'd6,
    ST_AR_HI     = 5'd7,
    ST_WD_LO     = 5'd8,
    ST_WD_HI     = 5'd9,
    ST_RD_LO     = 5'd10,
    ST_RD_HI     = 5'd11,
    ST_RS_LOW    = 5'd12,
    ST_RS_HIGH   = 5'd13,
    ST_RS_START  = 5'd14,
    ST_STOP_LOW  = 5'd15,
    ST_STOP_HIGH = 5'd16,
    ST_STOP_END  = 5'd17
  } step_t;

  logic [6:0]  slave_addr;
  logic [11:0] phase_ticks;
  logic [15:0] gap_phases;

  step_t       step, step_next;
  logic [11:0] phase_timer, phase_timer_next;
  logic [15:0] gap_counter, gap_counter_next;
  logic [3:0]  bit_pos, bit_pos_next;
  logic [2:0]  byte_pos, byte_pos_next;
  logic        is_read, is_read_next;
  logic [63:0] tx_shift, tx_shift_next;
  logic [55:0] rx_shift, rx_shift_next;

  i2cb_pkg::res_t res_next;
  logic        take;
  logic        start_cmd;
  logic        phase_end;
  logic [11:0] period;
  logic        rd_seg;
  step_t       seg_lo;

  assign take      = q_valid && (!res_valid || res_ready);
  assign q_pop     = take;
  assign start_cmd = (q_item.kind == i2cb_pkg::KIND_WRITE) ||
                     (q_item.kind == i2cb_pkg::KIND_READ);
  assign period    = (phase_ticks == 12'd0) ? 12'd1 : phase_ticks;
  assign phase_end = ({1'b0, phase_timer} + 13'd1) >= {1'b0, period};
  assign seg_lo    = step_t'(step - 5'd1);

  always_comb begin
    step_next        = step;
    phase_timer_next = phase_timer;
    gap_counter_next = gap_counter;
    bit_pos_next     = bit_pos;
    byte_pos_next    = byte_pos;
    is_read_next     = is_read;
    tx_shift_next    = tx_shift;
    rx_shift_next    = rx_shift;
    res_next         = '0;
    rd_seg           = 1'b0;

    unique case (step)
      ST_IDLE: begin
        if (start_cmd) begin
          is_read_next     = (q_item.kind == i2cb_pkg::KIND_READ);
          tx_shift_next    = {slave_addr, 1'b0, q_item.reg_addr,
                              (is_read_next ? {slave_addr, 1'b1} : 8'h00), 40'h0};
          rx_shift_next    = is_read_next ? 56'h0 : q_item.write_data;
          bit_pos_next     = 4'd0;
          byte_pos_next    = 3'd0;
          gap_counter_next = 16'd0;
          phase_timer_next = 12'd0;
          step_next        = ST_START;
        end
      end
      ST_START, ST_AW_LO, ST_AW_HI, ST_RG_LO, ST_RG_HI, ST_AR_LO, ST_AR_HI,
      ST_WD_LO, ST_WD_HI, ST_RD_LO, ST_RD_HI, ST_RS_LOW, ST_RS_HIGH,
      ST_RS_START, ST_STOP_LOW, ST_STOP_HIGH, ST_STOP_END: begin
        res_next.cmd_rejected = start_cmd;
        if (phase_end) begin
          phase_timer_next = 12'd0;
          unique case (step)
            ST_START:     step_next = ST_AW_LO;
            ST_AW_LO, ST_RG_LO, ST_AR_LO, ST_WD_LO, ST_RD_LO:
                          step_next = step_t'(step + 5'd1);
            ST_AW_HI, ST_RG_HI, ST_AR_HI, ST_WD_HI, ST_RD_HI: begin
              if (bit_pos < 4'd8) begin
                if (step == ST_RD_HI) begin
                  rx_shift_next = {rx_shift[54:0], q_item.sda_in};
                end else begin
                  tx_shift_next = {tx_shift[62:0], 1'b0};
                end
                bit_pos_next = bit_pos + 4'd1;
                step_next    = seg_lo;
              end else begin
                bit_pos_next = 4'd0;
                priority if (step == ST_AW_HI) begin
                  step_next = ST_RG_LO;
                end else if (step == ST_RG_HI) begin
                  if (is_read) begin
                    gap_counter_next = 16'd0;
                    step_next        = ST_RS_LOW;
                  end else begin
                    tx_shift_next = {rx_shift, 8'h00};
                    rx_shift_next = 56'h0;
                    byte_pos_next = 3'd0;
                    step_next     = ST_WD_LO;
                  end
                end else if (step == ST_AR_HI) begin
                  rx_shift_next = 56'h0;
                  byte_pos_next = 3'd0;
                  step_next     = ST_RD_LO;
                end else if (byte_pos >= LAST_BYTE) begin
                  step_next = ST_STOP_LOW;
                end else begin
                  byte_pos_next = byte_pos + 3'd1;
                  step_next     = seg_lo;
                end
              end
            end
            ST_RS_LOW: begin
              if (gap_counter < gap_phases) begin
                gap_counter_next = gap_counter + 16'd1;
              end else begin
                step_next = ST_RS_HIGH;
              end
            end
            ST_RS_HIGH:   step_next = ST_RS_START;
            ST_RS_START:  step_next = ST_AR_LO;
            ST_STOP_LOW:  step_next = ST_STOP_HIGH;
            ST_STOP_HIGH: step_next = ST_STOP_END;
            default: begin
              // end of STOP: burst complete
              step_next          = ST_IDLE;
              res_next.read_done = is_read;
              res_next.read_data = is_read ? rx_shift : 56'h0;
            end
          endcase
        end else begin
          phase_timer_next = phase_timer + 12'd1;
        end
      end
      default: begin
        // unreachable step code: drop back to idle
        step_next        = ST_IDLE;
        phase_timer_next = 12'd0;
      end
    endcase

    // Line levels follow the updated state.
    rd_seg = (step_next == ST_RD_LO) || (step_next == ST_RD_HI);
    unique case (step_next)
      ST_AW_LO, ST_AW_HI, ST_RG_LO, ST_RG_HI, ST_AR_LO, ST_AR_HI,
      ST_WD_LO, ST_WD_HI, ST_RD_LO, ST_RD_HI: begin
        res_next.scl_release = step_next[0];
        if (bit_pos_next < 4'd8) begin
          res_next.sda_release = rd_seg ? 1'b1 : tx_shift_next[63];
        end else begin
          // ACK slot: master ACKs read bytes but the last
          res_next.sda_release = rd_seg ? (byte_pos_next >= LAST_BYTE) : 1'b1;
        end
      end
      ST_START, ST_RS_START, ST_STOP_HIGH: begin
        res_next.scl_release = 1'b1;
        res_next.sda_release = 1'b0;
      end
      ST_RS_LOW: begin
        res_next.scl_release = 1'b0;
        res_next.sda_release = 1'b1;
      end
      ST_STOP_LOW: begin
        res_next.scl_release = 1'b0;
        res_next.sda_release = 1'b0;
      end
      default: begin
        res_next.scl_release = 1'b1;
        res_next.sda_release = 1'b1;
      end
    endcase
    res_next.busy_res = (step_next != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr  <= i2cb_pkg::SLAVE_ADDR_RST;
      phase_ticks <= i2cb_pkg::PHASE_RST;
      gap_phases  <= i2cb_pkg::GAP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        i2cb_pkg::CFG_SLAVE_ADDR: slave_addr  <= cfg_data[6:0];
        i2cb_pkg::CFG_PHASE:      phase_ticks <= cfg_data[11:0];
        i2cb_pkg::CFG_GAP:        gap_phases  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= ST_IDLE;
      phase_timer <= 12'd0;
      gap_counter <= 16'd0;
      bit_pos     <= 4'd0;
      byte_pos    <= 3'd0;
      is_read     <= 1'b0;
      tx_shift    <= 64'h0;
      rx_shift    <= 56'h0;
      res_valid   <= 1'b0;
      res         <= '0;
    end else begin
      if (take) begin
        step        <= step_next;
        phase_timer <= phase_timer_next;
        gap_counter <= gap_counter_next;
        bit_pos     <= bit_pos_next;
        byte_pos    <= byte_pos_next;
        is_read     <= is_read_next;
        tx_shift    <= tx_shift_next;
        rx_shift    <= rx_shift_next;
        res_valid   <= 1'b1;
        res         <= res_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_bit_range: assert property (@(posedge clk) disable iff (rst) bit_pos <= 4'd8)
    else $error("bit position beyond ACK slot");
  a_done_from_stop: assert property (@(posedge clk) disable iff (rst)
      take && res_next.read_done |-> step == ST_STOP_END && is_read)
    else $error("read_done outside the end of a read burst");
  a_idle_released: assert property (@(posedge clk) disable iff (rst)
      res_valid && !res.busy_res |-> res.scl_release && res.sda_release)
    else $error("lines not released while idle");
  a_no_reject_idle: assert property (@(posedge clk) disable iff (rst)
      take && step == ST_IDLE |=> !res.cmd_rejected)
    else $error("command rejected while idle");
`endif

endmodule

// File: src/i2c_master_register_burst.sv
// I2C master for fixed register bursts: each input transfer is registered in the queue, then the
// sequencer step that takes it loads the result register.
// Throughput: one tick item per cycle while the result is not stalled, set by the state update.
// Synchronous reset: config registers to 104/250/16, sequencer idle, result cleared, queue empty.
// Depends on i2cb_pkg, i2cb_front and i2cb_engine.
module i2c_master_register_burst #(
  parameter int unsigned BURST_BYTES = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // reg_addr[7:0], write_data[63:8], sda_in[64], zero[71:65]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // scl_release[0], sda_release[1], busy_res[2], read_done[3],
                                 // read_data[59:4], cmd_rejected[60], zero[63:61]
);

  logic            q_valid;
  i2cb_pkg::item_t q_item;
  logic            q_pop;
  i2cb_pkg::res_t  res;

  i2cb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_cmd       (s_tuser),
    .in_reg_addr  (s_tdata[7:0]),
    .in_write_data(s_tdata[63:8]),
    .in_sda       (s_tdata[64]),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  i2cb_engine #(
    .BURST_BYTES(BURST_BYTES)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  assign m_tdata = {3'b000, res.cmd_rejected, res.read_data, res.read_done,
                    res.busy_res, res.sda_release, res.scl_release};

endmodule

// File: bench/tb_i2c_master_register_burst.sv
// Self-checking bench for the I2C register-burst master: drives tick items on the input stream,
// predicts every result in step with the block, and checks each result as it leaves.
// Depends on i2cb_pkg and i2c_master_register_burst.
`timescale 1ns / 100ps

module tb_i2c_master_register_burst;

  localparam int unsigned BURST_BYTES = 7;
  localparam logic [2:0] LAST_BYTE = 3'(BURST_BYTES - 1);
  localparam logic [1:0] CMD_CODE_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 5000;

  typedef enum logic [4:0] {
    S_IDLE, S_START,
    S_ADDRW_LO, S_ADDRW_HI, S_REG_LO, S_REG_HI, S_ADDRR_LO, S_ADDRR_HI,
    S_WDATA_LO, S_WDATA_HI, S_RDATA_LO, S_RDATA_HI,
    S_RS_LOW, S_RS_HIGH, S_RS_START, S_STOP_LOW, S_STOP_HIGH, S_STOP_END
  } step_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;  // reg_addr[7:0], write_data[63:8], sda_in[64], zero[71:65]
  logic [1:0]  s_tuser = '0;  // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;       // scl_release[0], sda_release[1], busy_res[2], read_done[3],
                              // read_data[59:4], cmd_rejected[60], zero[63:61]

  // predicted bus master state and its copy of the registers
  logic [6:0]  cfg_slave = i2cb_pkg::SLAVE_ADDR_RST;
  logic [11:0] cfg_phase = i2cb_pkg::PHASE_RST;
  logic [15:0] cfg_gap = i2cb_pkg::GAP_RST;
  step_t       bus_step = S_IDLE;
  logic [11:0] phase_cnt = '0;
  logic [15:0] gap_cnt = '0;
  logic [3:0]  bit_pos = '0;
  logic [2:0]  byte_pos = '0;
  logic        rd_burst = 1'b0;
  logic [63:0] tx_sr = '0;
  logic [55:0] rx_sr = '0;

  i2cb_pkg::res_t expected_bus_states[$];
  int unsigned items_sent = 0;
  int unsigned errors = 0;
  int unsigned calm_left = 0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  i2c_master_register_burst #(.BURST_BYTES(BURST_BYTES)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm_left != 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [55:0] rand_word();
    return 56'({$urandom, $urandom});
  endfunction

  // Line levels {scl, sda} for the current sequencer step.
  function automatic logic [1:0] bus_levels();
    logic scl_hi;
    logic sda_hi;
    logic rd_seg;
    case (bus_step)
      S_ADDRW_LO, S_ADDRW_HI, S_REG_LO, S_REG_HI, S_ADDRR_LO, S_ADDRR_HI,
      S_WDATA_LO, S_WDATA_HI, S_RDATA_LO, S_RDATA_HI: begin
        scl_hi = (bus_step == S_ADDRW_HI) || (bus_step == S_REG_HI) ||
                 (bus_step == S_ADDRR_HI) || (bus_step == S_WDATA_HI) ||
                 (bus_step == S_RDATA_HI);
        rd_seg = (bus_step == S_RDATA_LO) || (bus_step == S_RDATA_HI);
        if (bit_pos < 4'd8) sda_hi = rd_seg ? 1'b1 : tx_sr[63];
        else if (rd_seg) sda_hi = (byte_pos >= LAST_BYTE);  // NACK the last byte
        else sda_hi = 1'b1;                                  // release for the slave ACK
        return {scl_hi, sda_hi};
      end
      S_START, S_RS_START, S_STOP_HIGH: return 2'b10;
      S_RS_LOW: return 2'b01;
      S_STOP_LOW: return 2'b00;
      default: return 2'b11;
    endcase
  endfunction

  task automatic end_of_phase(input logic sda, output logic burst_end);
    burst_end = 1'b0;
    case (bus_step)
      S_START: bus_step = S_ADDRW_LO;
      S_ADDRW_LO: bus_step = S_ADDRW_HI;
      S_REG_LO: bus_step = S_REG_HI;
      S_ADDRR_LO: bus_step = S_ADDRR_HI;
      S_WDATA_LO: bus_step = S_WDATA_HI;
      S_RDATA_LO: bus_step = S_RDATA_HI;
      S_ADDRW_HI, S_REG_HI, S_ADDRR_HI, S_WDATA_HI, S_RDATA_HI: begin
        if (bit_pos < 4'd8) begin
          if (bus_step == S_RDATA_HI) rx_sr = {rx_sr[54:0], sda};
          else tx_sr = tx_sr << 1;
          bit_pos = bit_pos + 4'd1;
          case (bus_step)
            S_ADDRW_HI: bus_step = S_ADDRW_LO;
            S_REG_HI: bus_step = S_REG_LO;
            S_ADDRR_HI: bus_step = S_ADDRR_LO;
            S_WDATA_HI: bus_step = S_WDATA_LO;
            default: bus_step = S_RDATA_LO;
          endcase
        end else begin
          bit_pos = '0;
          case (bus_step)
            S_ADDRW_HI: bus_step = S_REG_LO;
            S_REG_HI: begin
              if (rd_burst) begin
                gap_cnt = '0;
                bus_step = S_RS_LOW;
              end else begin
                // write data parked in the receive register moves out now
                tx_sr = {rx_sr, 8'h00};
                rx_sr = '0;
                byte_pos = '0;
                bus_step = S_WDATA_LO;
              end
            end
            S_ADDRR_HI: begin
              rx_sr = '0;
              byte_pos = '0;
              bus_step = S_RDATA_LO;
            end
            default: begin
              if (byte_pos >= LAST_BYTE) begin
                bus_step = S_STOP_LOW;
              end else begin
                byte_pos = byte_pos + 3'd1;
                bus_step = (bus_step == S_RDATA_HI) ? S_RDATA_LO : S_WDATA_LO;
              end
            end
          endcase
        end
      end
      S_RS_LOW: begin
        if (gap_cnt < cfg_gap) gap_cnt = gap_cnt + 16'd1;
        else bus_step = S_RS_HIGH;
      end
      S_RS_HIGH: bus_step = S_RS_START;
      S_RS_START: bus_step = S_ADDRR_LO;
      S_STOP_LOW: bus_step = S_STOP_HIGH;
      S_STOP_HIGH: bus_step = S_STOP_END;
      default: begin
        bus_step = S_IDLE;
        burst_end = 1'b1;
      end
    endcase
  endtask

  task automatic predict_bus_tick(input logic [1:0] cmd, input logic [7:0] ra,
                                  input logic [55:0] wd, input logic sda,
                                  output i2cb_pkg::res_t r);
    logic [11:0] period;
    logic        is_start;
    logic        burst_end;
    logic [1:0]  lv;
    r = '0;
    period = (cfg_phase == 12'd0) ? 12'd1 : cfg_phase;
    is_start = (cmd == i2cb_pkg::CMD_CODE_WRITE) || (cmd == i2cb_pkg::CMD_CODE_READ);
    if (bus_step == S_IDLE) begin
      if (is_start) begin
        rd_burst = (cmd == i2cb_pkg::CMD_CODE_READ);
        tx_sr = {cfg_slave, 1'b0, ra, 48'd0};
        if (rd_burst) begin
          tx_sr[47:40] = {cfg_slave, 1'b1};
          rx_sr = '0;
        end else begin
          rx_sr = wd;
        end
        bit_pos = '0;
        byte_pos = '0;
        gap_cnt = '0;
        phase_cnt = '0;
        bus_step = S_START;
      end
    end else begin
      r.cmd_rejected = is_start;
      if ({1'b0, phase_cnt} + 13'd1 >= {1'b0, period}) begin
        phase_cnt = '0;
        end_of_phase(sda, burst_end);
        if (burst_end && rd_burst) begin
          r.read_done = 1'b1;
          r.read_data = rx_sr;
        end
      end else begin
        phase_cnt = phase_cnt + 12'd1;
      end
    end
    lv = bus_levels();
    r.scl_release = lv[1];
    r.sda_release = lv[0];
    r.busy_res = (bus_step != S_IDLE);
  endtask

  // Hold valid across back-to-back items; drop it only for a gap.
  task automatic send_tick(input logic [1:0] cmd, input logic [7:0] ra,
                           input logic [55:0] wd, input logic sda);
    int unsigned gap;
    i2cb_pkg::res_t r;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= {7'd0, sda, wd, ra};
    s_tuser <= cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_bus_tick(cmd, ra, wd, sda, r);
    expected_bus_states.push_back(r);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_bus_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      i2cb_pkg::CFG_SLAVE_ADDR: cfg_slave = value[6:0];
      i2cb_pkg::CFG_PHASE: cfg_phase = value[11:0];
      default: cfg_gap = value;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Start a burst and tick until it has finished; noise_pct of the ticks carry a stray command.
  task automatic run_burst(input logic [1:0] start_cmd, input logic [7:0] ra,
                           input logic [55:0] wd, input int unsigned noise_pct);
    logic [1:0] c;
    send_tick(start_cmd, ra, wd, 1'($urandom));
    while (bus_step != S_IDLE) begin
      c = i2cb_pkg::CMD_CODE_TICK;
      if ($urandom_range(0, 99) < noise_pct) begin
        case ($urandom_range(0, 2))
          0: c = i2cb_pkg::CMD_CODE_WRITE;
          1: c = i2cb_pkg::CMD_CODE_READ;
          default: c = CMD_CODE_UNUSED;
        endcase
      end
      send_tick(c, 8'($urandom), rand_word(), 1'($urandom));
    end
  endtask

  task automatic test_idle_ticks();
    send_tick(i2cb_pkg::CMD_CODE_TICK, 8'h00, 56'd0, 1'b0);
    send_tick(i2cb_pkg::CMD_CODE_TICK, 8'hFF, {56{1'b1}}, 1'b1);
    send_tick(CMD_CODE_UNUSED, 8'hFF, {56{1'b1}}, 1'b0);
    send_tick(CMD_CODE_UNUSED, 8'h00, 56'd0, 1'b1);
  endtask

  task automatic test_write_bursts();
    write_register(i2cb_pkg::CFG_PHASE, 16'd0);  // zero length behaves as one tick
    run_burst(i2cb_pkg::CMD_CODE_WRITE, 8'hFF, {56{1'b1}}, 0);
    write_register(i2cb_pkg::CFG_SLAVE_ADDR, 16'd127);
    run_burst(i2cb_pkg::CMD_CODE_WRITE, 8'h00, 56'd0, 15);
    write_register(i2cb_pkg::CFG_PHASE, 16'd2);
    write_register(i2cb_pkg::CFG_SLAVE_ADDR, 16'd0);
    run_burst(i2cb_pkg::CMD_CODE_WRITE, 8'h5A, 56'hA5_0F_F0_33_CC_81_7E, 5);
  endtask

  task automatic test_read_bursts();
    write_register(i2cb_pkg::CFG_PHASE, 16'd1);
    write_register(i2cb_pkg::CFG_GAP, 16'd0);
    run_burst(i2cb_pkg::CMD_CODE_READ, 8'hA5, rand_word(), 0);
    write_register(i2cb_pkg::CFG_SLAVE_ADDR, 16'd127);
    write_register(i2cb_pkg::CFG_GAP, 16'd3);
    run_burst(i2cb_pkg::CMD_CODE_READ, 8'hFF, rand_word(), 15);
  endtask

  task automatic test_random_bursts();
    int unsigned start_count;
    logic [1:0] kind;
    start_count = items_sent;
    while (items_sent - start_count < 300) begin
      if ($urandom_range(0, 2) == 0) begin
        write_register(i2cb_pkg::CFG_SLAVE_ADDR, 16'($urandom_range(0, 127)));
        write_register(i2cb_pkg::CFG_PHASE,
                       ($urandom_range(0, 9) < 7) ? 16'd1 : 16'($urandom_range(2, 5)));
        write_register(i2cb_pkg::CFG_GAP,
                       ($urandom_range(0, 9) < 8) ? 16'($urandom_range(0, 4))
                                                  : 16'($urandom_range(5, 40)));
      end
      repeat ($urandom_range(0, 6))
        send_tick($urandom_range(0, 1) ? i2cb_pkg::CMD_CODE_TICK : CMD_CODE_UNUSED,
                  8'($urandom), rand_word(), 1'($urandom));
      kind = $urandom_range(0, 1) ? i2cb_pkg::CMD_CODE_WRITE : i2cb_pkg::CMD_CODE_READ;
      run_burst(kind, 8'($urandom), rand_word(), 4);
    end
  endtask

  task automatic test_long_restart_gap();
    write_register(i2cb_pkg::CFG_PHASE, 16'd1);
    write_register(i2cb_pkg::CFG_GAP, 16'd150);
    run_burst(i2cb_pkg::CMD_CODE_READ, 8'($urandom), rand_word(), 1);
  endtask

  // Slowest bus for the opening of a burst, then a short phase takes over mid-burst.
  task automatic test_slow_phase();
    write_register(i2cb_pkg::CFG_PHASE, 16'd4095);
    send_tick(i2cb_pkg::CMD_CODE_WRITE, 8'($urandom), rand_word(), 1'($urandom));
    repeat (200)
      send_tick(($urandom_range(0, 99) < 2) ? i2cb_pkg::CMD_CODE_READ
                                             : i2cb_pkg::CMD_CODE_TICK,
                8'($urandom), rand_word(), 1'($urandom));
    write_register(i2cb_pkg::CFG_PHASE, 16'd1);
    while (bus_step != S_IDLE)
      send_tick(i2cb_pkg::CMD_CODE_TICK, 8'($urandom), rand_word(), 1'($urandom));
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_ticks();
    test_write_bursts();
    test_read_bursts();
    test_random_bursts();
    test_long_restart_gap();
    test_slow_phase();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("i2c_master_register_burst test passed");
    end else begin
      $display("i2c_master_register_burst test failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (m_tvalid && m_tready) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    i2cb_pkg::res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bus_states.size() == 0) begin
        $error("result transfer with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        want = expected_bus_states.pop_front();
        if (m_tdata[0] !== want.scl_release) begin
          $error("scl_release: expected %0b, got %0b", want.scl_release, m_tdata[0]);
          errors++;
        end
        if (m_tdata[1] !== want.sda_release) begin
          $error("sda_release: expected %0b, got %0b", want.sda_release, m_tdata[1]);
          errors++;
        end
        if (m_tdata[2] !== want.busy_res) begin
          $error("busy_res: expected %0b, got %0b", want.busy_res, m_tdata[2]);
          errors++;
        end
        if (m_tdata[3] !== want.read_done) begin
          $error("read_done: expected %0b, got %0b", want.read_done, m_tdata[3]);
          errors++;
        end
        if (m_tdata[59:4] !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, m_tdata[59:4]);
          errors++;
        end
        if (m_tdata[60] !== want.cmd_rejected) begin
          $error("cmd_rejected: expected %0b, got %0b", want.cmd_rejected, m_tdata[60]);
          errors++;
        end
      end
    end
  end

  // Stop a hung run: count cycles with no transfer on either stream.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("i2c_master_register_burst test failed");
        $finish;
      end
    end
  end

endmodule

// File: i2c_master_register_burst.f
src/i2cb_pkg.sv
src/i2cb_front.sv
src/i2cb_engine.sv
src/i2c_master_register_burst.sv
bench/tb_i2c_master_register_burst.sv
